// ===== rtl/assert_macros.svh =====
// Assertion macros for the particle collision RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic clocked assertion with asynchronous active-low reset
`define PCR_ASSERT(label, ck, rn, prop, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// shorthand on the standard clk / rst_n pair
`define PCR_CHECK(label, prop, msg) `PCR_ASSERT(label, clk, rst_n, prop, msg)

`endif

// ===== rtl/pcr_pkg.sv =====
// Package: types, constants and fixed-point helpers for the collision pipeline.
`timescale 1ns / 1ps
`default_nettype none
package pcr_pkg;

    localparam int FRAC = 16;
    localparam int ISQ_STAGES = 32;
    localparam int DIV_BITS = 17;

    localparam logic [16:0] ONE = 17'(1) << FRAC;
    localparam logic [71:0] HALF = 72'(1) << (FRAC - 1);
    localparam logic signed [71:0] SAT_MAX = 72'sd2147483647;
    localparam logic signed [71:0] SAT_MIN = -72'sd2147483648;

    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_REST   = 2'd1;
    localparam logic [1:0] REG_FRIC   = 2'd2;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [17:0] nx;
        logic signed [17:0] ny;
        logic        [30:0] surf_dist;
        logic signed [31:0] wx;
        logic signed [31:0] wy;
    } in_t;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic        collided;
    } out_t;

    typedef struct packed {
        in_t                p;
        logic signed [50:0] prod_sx;
        logic signed [50:0] prod_sy;
        logic signed [49:0] prod_rx;
        logic signed [49:0] prod_ry;
        logic signed [50:0] prod_dx;
        logic signed [50:0] prod_dy;
        logic signed [32:0] rvx;
        logic signed [32:0] rvy;
        logic               pen;
        logic               appr;
        logic        [31:0] opx;
        logic        [31:0] opy;
        logic signed [35:0] dn;
        logic        [35:0] adn;
        logic signed [53:0] prod_vx;
        logic signed [53:0] prod_vy;
        logic        [53:0] prod_d;
        logic signed [37:0] vnx;
        logic signed [37:0] vny;
        logic        [38:0] d;
        logic signed [38:0] vtx;
        logic signed [38:0] vty;
        logic signed [55:0] prod_ex;
        logic signed [55:0] prod_ey;
        logic        [3:0]  sh;
        logic        [30:0] ax;
        logic        [30:0] ay;
        logic               vt_zero;
        logic signed [39:0] nvx;
        logic signed [39:0] nvy;
        logic        [61:0] sqx;
        logic        [61:0] sqy;
        logic        [50:0] pp_lo;
        logic        [49:0] pp_hi;
        logic               unity;
        logic        [63:0] sqrem;
        logic        [63:0] sqroot;
        logic        [39:0] len;
        logic               sat0;
        logic        [56:0] rem;
        logic        [16:0] q;
        logic signed [56:0] tvx;
        logic signed [56:0] tvy;
    } item_t;

    // round to nearest, ties away from zero, drop FRAC bits
    function automatic logic signed [71:0] rnd_q(input logic signed [71:0] v);
        logic [71:0] mag;
        logic [71:0] r;
        mag = v[71] ? 72'(-v) : 72'(v);
        r = (mag + HALF) >> FRAC;
        return v[71] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic [31:0] sat32(input logic signed [71:0] v);
        logic [31:0] r;
        if (v > SAT_MAX)
            r = 32'h7fff_ffff;
        else if (v < SAT_MIN)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/pcr_front.sv =====
// Front pipeline: penetration test, normal/tangent split, squares and friction products.
`timescale 1ns / 1ps
`default_nettype none
module pcr_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire pcr_pkg::in_t  in_item,
    input  wire logic [30:0]   r,
    input  wire logic [16:0]   e,
    input  wire logic [30:0]   mu,
    output logic               out_valid,
    output pcr_pkg::item_t     out_item
);

    pcr_pkg::item_t st1_reg, st2_reg, st3_reg, st4_reg, st5_reg, st6_reg, st7_reg;
    pcr_pkg::item_t st1_next, st2_next, st3_next, st4_next, st5_next, st6_next, st7_next;
    logic [6:0] vld_reg;

    // stage 1: differences and first products
    always_comb
    begin
        logic signed [32:0] dpx;
        logic signed [32:0] dpy;
        st1_next = '0;
        st1_next.p = in_item;
        dpx = {in_item.px[31], in_item.px} - {in_item.cx[31], in_item.cx};
        dpy = {in_item.py[31], in_item.py} - {in_item.cy[31], in_item.cy};
        st1_next.rvx = {in_item.vx[31], in_item.vx} - {in_item.wx[31], in_item.wx};
        st1_next.rvy = {in_item.vy[31], in_item.vy} - {in_item.wy[31], in_item.wy};
        st1_next.prod_sx = dpx * in_item.nx;
        st1_next.prod_sy = dpy * in_item.ny;
        st1_next.prod_rx = $signed({1'b0, r}) * in_item.nx;
        st1_next.prod_ry = $signed({1'b0, r}) * in_item.ny;
        st1_next.prod_dx = st1_next.rvx * in_item.nx;
        st1_next.prod_dy = st1_next.rvy * in_item.ny;
    end

    // stage 2: tests, moved position, normal speed
    always_comb
    begin
        logic signed [51:0] side;
        logic signed [51:0] dnr;
        logic signed [71:0] w72;
        st2_next = st1_reg;
        side = st1_reg.prod_sx + st1_reg.prod_sy;
        st2_next.pen = side[51] | (st1_reg.p.surf_dist < r);
        w72 = pcr_pkg::rnd_q(72'(st1_reg.prod_rx)) + st1_reg.p.cx;
        st2_next.opx = pcr_pkg::sat32(w72);
        w72 = pcr_pkg::rnd_q(72'(st1_reg.prod_ry)) + st1_reg.p.cy;
        st2_next.opy = pcr_pkg::sat32(w72);
        dnr = st1_reg.prod_dx + st1_reg.prod_dy;
        st2_next.appr = dnr[51];
        w72 = pcr_pkg::rnd_q(72'(dnr));
        st2_next.dn = w72[35:0];
        st2_next.adn = w72[71] ? 36'(-w72) : w72[35:0];
    end

    // stage 3: normal velocity and restitution products
    always_comb
    begin
        logic [17:0] opl;
        st3_next = st2_reg;
        opl = 18'(pcr_pkg::ONE) + 18'(e);
        st3_next.prod_vx = st2_reg.dn * st2_reg.p.nx;
        st3_next.prod_vy = st2_reg.dn * st2_reg.p.ny;
        st3_next.prod_d = opl * st2_reg.adn;
    end

    // stage 4: vn, vt, |dvn|
    always_comb
    begin
        logic signed [71:0] w72;
        logic [54:0] dsum;
        logic [54:0] dsh;
        st4_next = st3_reg;
        w72 = pcr_pkg::rnd_q(72'(st3_reg.prod_vx));
        st4_next.vnx = w72[37:0];
        w72 = pcr_pkg::rnd_q(72'(st3_reg.prod_vy));
        st4_next.vny = w72[37:0];
        st4_next.vtx = st3_reg.rvx - st4_next.vnx;
        st4_next.vty = st3_reg.rvy - st4_next.vny;
        dsum = {1'b0, st3_reg.prod_d} + pcr_pkg::HALF[54:0];
        dsh = dsum >> pcr_pkg::FRAC;
        st4_next.d = dsh[38:0];
    end

    // stage 5: restitution products, tangent magnitude prescale
    always_comb
    begin
        logic [38:0] abx;
        logic [38:0] aby;
        logic [38:0] tx;
        logic [38:0] ty;
        st5_next = st4_reg;
        st5_next.prod_ex = $signed({1'b0, e}) * st4_reg.vnx;
        st5_next.prod_ey = $signed({1'b0, e}) * st4_reg.vny;
        abx = st4_reg.vtx[38] ? 39'(-st4_reg.vtx) : 39'(st4_reg.vtx);
        aby = st4_reg.vty[38] ? 39'(-st4_reg.vty) : 39'(st4_reg.vty);
        st5_next.sh = 4'd8;
        for (int s = 8; s >= 0; s--)
        begin
            tx = abx >> s;
            ty = aby >> s;
            if (tx[38:31] == 8'd0 && ty[38:31] == 8'd0)
                st5_next.sh = 4'(s);
        end
        tx = abx >> st5_next.sh;
        ty = aby >> st5_next.sh;
        st5_next.ax = tx[30:0];
        st5_next.ay = ty[30:0];
        st5_next.vt_zero = (st4_reg.vtx == '0) && (st4_reg.vty == '0);
    end

    // stage 6: reflected normal part, squares
    always_comb
    begin
        logic signed [71:0] w72;
        st6_next = st5_reg;
        w72 = pcr_pkg::rnd_q(72'(st5_reg.prod_ex));
        st6_next.nvx = -$signed(w72[39:0]);
        w72 = pcr_pkg::rnd_q(72'(st5_reg.prod_ey));
        st6_next.nvy = -$signed(w72[39:0]);
        st6_next.sqx = st5_reg.ax * st5_reg.ax;
        st6_next.sqy = st5_reg.ay * st5_reg.ay;
    end

    // stage 7: root operand, friction partial products
    always_comb
    begin
        logic [62:0] sum;
        st7_next = st6_reg;
        sum = {1'b0, st6_reg.sqx} + {1'b0, st6_reg.sqy};
        st7_next.sqrem = {1'b0, sum};
        st7_next.sqroot = '0;
        st7_next.pp_lo = mu * st6_reg.d[19:0];
        st7_next.pp_hi = mu * st6_reg.d[38:20];
        st7_next.unity = (mu == '0) | (st6_reg.d == '0) | st6_reg.vt_zero;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[5:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st1_reg <= st1_next;
            st2_reg <= st2_next;
            st3_reg <= st3_next;
            st4_reg <= st4_next;
            st5_reg <= st5_next;
            st6_reg <= st6_next;
            st7_reg <= st7_next;
        end
    end

    assign out_valid = vld_reg[6];
    assign out_item  = st7_reg;

endmodule
`default_nettype wire

// ===== rtl/pcr_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module pcr_isqrt (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire pcr_pkg::item_t  in_item,
    output logic                 out_valid,
    output pcr_pkg::item_t       out_item
);

    localparam int N = pcr_pkg::ISQ_STAGES;

    pcr_pkg::item_t src [N];
    pcr_pkg::item_t st_next [N];
    pcr_pkg::item_t st_reg [N];
    logic [N-1:0] vld_reg;

    assign src[0] = in_item;

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        localparam logic [63:0] BITV = 64'd1 << (62 - 2 * k);
        if (k > 0)
        begin : g_link
            assign src[k] = st_reg[k-1];
        end
        always_comb
        begin
            logic [63:0] t;
            st_next[k] = src[k];
            t = src[k].sqroot + BITV;
            if (src[k].sqrem >= t)
            begin
                st_next[k].sqrem = src[k].sqrem - t;
                st_next[k].sqroot = (src[k].sqroot >> 1) + BITV;
            end
            else
            begin
                st_next[k].sqroot = src[k].sqroot >> 1;
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
                st_reg[k] <= st_next[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[N-2:0], in_valid};
    end

    assign out_valid = vld_reg[N-1];
    assign out_item  = st_reg[N-1];

endmodule
`default_nettype wire

// ===== rtl/pcr_div.sv =====
// Friction ratio: length setup, saturation test and pipelined restoring divider.
`timescale 1ns / 1ps
`default_nettype none
module pcr_div (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire pcr_pkg::item_t  in_item,
    output logic                 out_valid,
    output pcr_pkg::item_t       out_item
);

    localparam int N = pcr_pkg::DIV_BITS;

    pcr_pkg::item_t prep_next, prep_reg;
    pcr_pkg::item_t src [N];
    pcr_pkg::item_t st_next [N];
    pcr_pkg::item_t st_reg [N];
    logic [N:0] vld_reg;

    // setup: len, mu*|dvn|, compare against len scaled up, rounded dividend
    always_comb
    begin
        logic [69:0] num;
        logic [69:0] lim;
        prep_next = in_item;
        prep_next.len = 40'(in_item.sqroot[31:0]) << in_item.sh;
        num = 70'(in_item.pp_lo) + (70'(in_item.pp_hi) << 20);
        lim = 70'(prep_next.len) << pcr_pkg::FRAC;
        prep_next.sat0 = num >= lim;
        prep_next.rem = num[56:0] + 57'(prep_next.len >> 1);
        prep_next.q = '0;
    end

    assign src[0] = prep_reg;

    for (genvar j = 0; j < N; j++)
    begin : g_stage
        localparam int K = N - 1 - j;
        if (j > 0)
        begin : g_link
            assign src[j] = st_reg[j-1];
        end
        always_comb
        begin
            logic [56:0] t;
            st_next[j] = src[j];
            t = 57'(src[j].len) << K;
            if (src[j].rem >= t)
            begin
                st_next[j].rem = src[j].rem - t;
                st_next[j].q[K] = 1'b1;
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
                st_reg[j] <= st_next[j];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            prep_reg <= prep_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[N-1:0], in_valid};
    end

    assign out_valid = vld_reg[N];
    assign out_item  = st_reg[N-1];

endmodule
`default_nettype wire

// ===== rtl/pcr_back.sv =====
// Back pipeline: friction scale on the tangent part, result assembly and output register.
`timescale 1ns / 1ps
`default_nettype none
module pcr_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire pcr_pkg::item_t  in_item,
    output logic                 out_valid,
    output pcr_pkg::out_t        out_data
);

    pcr_pkg::item_t sc_next, sc_reg;
    pcr_pkg::out_t  out_next, out_reg;
    logic [1:0] vld_reg;

    always_comb
    begin
        logic [16:0] s;
        sc_next = in_item;
        if (in_item.unity)
            s = pcr_pkg::ONE;
        else if (in_item.sat0)
            s = '0;
        else
            s = pcr_pkg::ONE - in_item.q;
        sc_next.tvx = in_item.vtx * $signed({1'b0, s});
        sc_next.tvy = in_item.vty * $signed({1'b0, s});
    end

    always_comb
    begin
        logic signed [71:0] vx72;
        logic signed [71:0] vy72;
        vx72 = pcr_pkg::rnd_q(72'(sc_reg.tvx)) + sc_reg.nvx + sc_reg.p.wx;
        vy72 = pcr_pkg::rnd_q(72'(sc_reg.tvy)) + sc_reg.nvy + sc_reg.p.wy;
        out_next.collided = sc_reg.pen;
        out_next.pos_x = sc_reg.pen ? sc_reg.opx : sc_reg.p.px;
        out_next.pos_y = sc_reg.pen ? sc_reg.opy : sc_reg.p.py;
        if (sc_reg.pen && sc_reg.appr)
        begin
            out_next.vel_x = pcr_pkg::sat32(vx72);
            out_next.vel_y = pcr_pkg::sat32(vy72);
        end
        else
        begin
            out_next.vel_x = sc_reg.p.vx;
            out_next.vel_y = sc_reg.p.vy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sc_reg  <= sc_next;
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[0], in_valid};
    end

    assign out_valid = vld_reg[1];
    assign out_data  = out_reg;

endmodule
`default_nettype wire

// ===== rtl/particle_collision_response_2d_top.sv =====
// Top level: particle collision response with restitution and friction, Q16.16.
// Input stream (s_*): one beat per particle, candidate state plus surface query.
// Output stream (m_*): one beat per input beat, same order; tuser is the collided flag.
// APB port: radius at 0x0, restitution at 0x4, friction at 0x8; write only while idle.
// Pipeline: 7 front stages, 32 root stages, 18 divider stages, 2 back stages.
// Throughput: one beat per cycle while the output is not stalled; the 32-stage square
// root and the 17-bit restoring divider are fully pipelined.
// Stall: when the output beat is not taken, the whole pipeline holds and
// s_tready drops in the same cycle; nothing is lost or repeated.
// Reset: clears all pipeline valid bits and the three registers to zero.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module particle_collision_response_2d_top (
    input  wire logic          clk,
    input  wire logic          rst_n,
    // pos_x, pos_y, vel_x, vel_y, closest_x, closest_y, normal_x, normal_y,
    // surface_distance, wall_vel_x, wall_vel_y, zero pad
    input  wire logic [327:0]  s_tdata,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // out_pos_x, out_pos_y, out_vel_x, out_vel_y
    output logic [127:0]       m_tdata,
    // collided
    output logic [0:0]         m_tuser,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [30:0] radius_reg;
    logic [16:0] restitution_reg;
    logic [30:0] friction_reg;

    pcr_pkg::in_t   in_item;
    pcr_pkg::item_t fr_item, sq_item, dv_item;
    pcr_pkg::out_t  res;
    logic fr_valid, sq_valid, dv_valid, out_valid;
    logic en;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg      <= '0;
            restitution_reg <= '0;
            friction_reg    <= '0;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                pcr_pkg::REG_RADIUS: radius_reg      <= pwdata[30:0];
                pcr_pkg::REG_REST:   restitution_reg <= pwdata[16:0];
                pcr_pkg::REG_FRIC:   friction_reg    <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            pcr_pkg::REG_RADIUS: prdata = {1'b0, radius_reg};
            pcr_pkg::REG_REST:   prdata = {15'd0, restitution_reg};
            pcr_pkg::REG_FRIC:   prdata = {1'b0, friction_reg};
            default:             prdata = '0;
        endcase
    end

    assign in_item.px        = s_tdata[31:0];
    assign in_item.py        = s_tdata[63:32];
    assign in_item.vx        = s_tdata[95:64];
    assign in_item.vy        = s_tdata[127:96];
    assign in_item.cx        = s_tdata[159:128];
    assign in_item.cy        = s_tdata[191:160];
    assign in_item.nx        = s_tdata[209:192];
    assign in_item.ny        = s_tdata[227:210];
    assign in_item.surf_dist = s_tdata[258:228];
    assign in_item.wx        = s_tdata[290:259];
    assign in_item.wy        = s_tdata[322:291];

    assign en       = ~out_valid | m_tready;
    assign s_tready = en;

    pcr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_item   (in_item),
        .r         (radius_reg),
        .e         (restitution_reg),
        .mu        (friction_reg),
        .out_valid (fr_valid),
        .out_item  (fr_item)
    );

    pcr_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .in_item   (fr_item),
        .out_valid (sq_valid),
        .out_item  (sq_item)
    );

    pcr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_item   (sq_item),
        .out_valid (dv_valid),
        .out_item  (dv_item)
    );

    pcr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (dv_valid),
        .in_item   (dv_item),
        .out_valid (out_valid),
        .out_data  (res)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {res.vel_y, res.vel_x, res.pos_y, res.pos_x};
    assign m_tuser  = res.collided;

    `PCR_CHECK(a_ready_when_empty, !m_tvalid |-> s_tready, "input blocked with empty output")
    `PCR_CHECK(a_stall_blocks_input, m_tvalid && !m_tready |-> !s_tready, "input taken during stall")
    `PCR_CHECK(a_rest_write, wr_en && paddr[3:2] == pcr_pkg::REG_REST |=> restitution_reg == $past(pwdata[16:0]), "restitution write lost")

endmodule
`default_nettype wire
